[rtl/core/hsv_to_rgb_convert_macros.svh]
// Assertion macros for the HSV to RGB converter checker.
// Uses clk and rst_n of the module that includes this header.
`ifndef HSV_TO_RGB_CONVERT_MACROS_SVH
`define HSV_TO_RGB_CONVERT_MACROS_SVH

// Checked only while out of reset.
`define HSV2RGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define HSV2RGB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/hsv2rgb_pkg.sv]
// Shared types and constants of the HSV to RGB converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HUE_W  = 15;
  localparam int unsigned CHAN_W = 13;
  localparam int unsigned FRAC_W = 12;  // position inside one sector, below 3840
  localparam int unsigned SX_W   = CHAN_W + FRAC_W;
  localparam int unsigned N_W    = 17;  // scaled product before the divide by 15

  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;

  // 3840 = 15 << 8
  localparam int unsigned SECTOR_SHIFT = 8;

  // floor(n / 15) = (n * DIV15_MUL) >> DIV15_SHIFT for every n below 2**N_W
  localparam int unsigned DIV15_SHIFT = 24;
  localparam logic [20:0] DIV15_MUL   = 21'd1118482;

  typedef enum logic [2:0] {
    SECT_0 = 3'd0,
    SECT_1 = 3'd1,
    SECT_2 = 3'd2,
    SECT_3 = 3'd3,
    SECT_4 = 3'd4,
    SECT_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  typedef struct packed {
    sector_t            sector;
    logic               grey;
    logic [CHAN_W-1:0]  vc;
  } side_t;

endpackage

`default_nettype wire

[rtl/core/hsv2rgb_sector.sv]
// First pipeline stage: hue wrap, sector decode and position within the sector.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_sector (
  input  logic                                clk,
  input  logic                                en,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]      saturation,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]      brightness,
  output hsv2rgb_pkg::sector_t                sector,
  output logic [hsv2rgb_pkg::FRAC_W-1:0]      frac,
  output logic [hsv2rgb_pkg::FRAC_W-1:0]      frac_c,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]      sat,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]      bright
);

  logic [hsv2rgb_pkg::HUE_W-1:0]  hue_w;
  logic [hsv2rgb_pkg::HUE_W-1:0]  base;
  logic [hsv2rgb_pkg::HUE_W-1:0]  offs;
  hsv2rgb_pkg::sector_t           sector_nxt;
  logic [hsv2rgb_pkg::FRAC_W-1:0] frac_nxt;

  hsv2rgb_pkg::sector_t           sector_r;
  logic [hsv2rgb_pkg::FRAC_W-1:0] frac_r;
  logic [hsv2rgb_pkg::FRAC_W-1:0] frac_c_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0] sat_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0] bright_r;

  always_comb begin
    // a full turn or more counts as zero
    hue_w = (hue >= hsv2rgb_pkg::HUE_FULL) ? '0 : hue;
    if (hue_w >= 15'(hsv2rgb_pkg::HUE_SECTOR * 5)) begin
      sector_nxt = hsv2rgb_pkg::SECT_5;
      base       = 15'(hsv2rgb_pkg::HUE_SECTOR * 5);
    end else if (hue_w >= 15'(hsv2rgb_pkg::HUE_SECTOR * 4)) begin
      sector_nxt = hsv2rgb_pkg::SECT_4;
      base       = 15'(hsv2rgb_pkg::HUE_SECTOR * 4);
    end else if (hue_w >= 15'(hsv2rgb_pkg::HUE_SECTOR * 3)) begin
      sector_nxt = hsv2rgb_pkg::SECT_3;
      base       = 15'(hsv2rgb_pkg::HUE_SECTOR * 3);
    end else if (hue_w >= 15'(hsv2rgb_pkg::HUE_SECTOR * 2)) begin
      sector_nxt = hsv2rgb_pkg::SECT_2;
      base       = 15'(hsv2rgb_pkg::HUE_SECTOR * 2);
    end else if (hue_w >= hsv2rgb_pkg::HUE_SECTOR) begin
      sector_nxt = hsv2rgb_pkg::SECT_1;
      base       = hsv2rgb_pkg::HUE_SECTOR;
    end else begin
      sector_nxt = hsv2rgb_pkg::SECT_0;
      base       = '0;
    end
    offs     = hue_w - base;
    frac_nxt = offs[hsv2rgb_pkg::FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector_r <= sector_nxt;
      frac_r   <= frac_nxt;
      frac_c_r <= hsv2rgb_pkg::FRAC_W'(hsv2rgb_pkg::HUE_SECTOR) - frac_nxt;
      sat_r    <= saturation;
      bright_r <= brightness;
    end
  end

  assign sector = sector_r;
  assign frac   = frac_r;
  assign frac_c = frac_c_r;
  assign sat    = sat_r;
  assign bright = bright_r;

endmodule

`default_nettype wire

[rtl/core/hsv2rgb_scale.sv]
// Stages two to four for one term: v * (1 - s * x / 3840), truncated and clamped.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_scale #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                               clk,
  input  hsv2rgb_pkg::stage_en_t             en,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]     sat,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]     bright,
  input  logic [hsv2rgb_pkg::FRAC_W-1:0]     span,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]     level
);

  localparam int unsigned DEN_W  = FRAC_BITS + hsv2rgb_pkg::FRAC_W;
  localparam int unsigned SX_W   = hsv2rgb_pkg::SX_W;
  localparam int unsigned NUM_W  = ((DEN_W > SX_W) ? DEN_W : SX_W) + 1;
  localparam int unsigned PROD_W = hsv2rgb_pkg::CHAN_W + DEN_W;
  localparam int unsigned SHIFT  = FRAC_BITS + hsv2rgb_pkg::SECTOR_SHIFT;
  localparam int unsigned QM_W   = hsv2rgb_pkg::N_W + $bits(hsv2rgb_pkg::DIV15_MUL);
  localparam int unsigned ONE    = 1 << FRAC_BITS;
  localparam logic [DEN_W-1:0] DEN = DEN_W'(hsv2rgb_pkg::HUE_SECTOR) << FRAC_BITS;

  logic [SX_W-1:0]                  sx;
  logic signed [NUM_W-1:0]          num;
  logic [DEN_W-1:0]                 mag_nxt;
  logic [PROD_W-1:0]                prod;
  logic [QM_W-1:0]                  qm;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   quot;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   level_nxt;

  logic [DEN_W-1:0]                 mag_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   bright_r;
  logic [hsv2rgb_pkg::N_W-1:0]      n_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   level_r;

  always_comb begin
    sx      = SX_W'(sat) * SX_W'(span);
    num     = $signed(NUM_W'(DEN)) - $signed(NUM_W'(sx));
    // a term that goes negative gives zero
    mag_nxt = (num > 0) ? num[DEN_W-1:0] : '0;
  end

  always_comb begin
    prod = PROD_W'(bright_r) * PROD_W'(mag_r);
  end

  always_comb begin
    qm        = QM_W'(n_r) * QM_W'(hsv2rgb_pkg::DIV15_MUL);
    quot      = qm[hsv2rgb_pkg::DIV15_SHIFT +: hsv2rgb_pkg::CHAN_W];
    level_nxt = (32'(quot) > ONE) ? hsv2rgb_pkg::CHAN_W'(ONE) : quot;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      mag_r    <= mag_nxt;
      bright_r <= bright;
    end
    if (en.s3) begin
      // divide by 2**(FRAC_BITS+8) here, by 15 in the next stage
      n_r <= prod[SHIFT +: hsv2rgb_pkg::N_W];
    end
    if (en.s4) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

`default_nettype wire

[rtl/core/hsv_to_rgb_convert.sv]
// HSV to RGB converter: five register stages, one request per cycle.
// A request moves through the sector stage, the scale stages and the output register.
// Throughput: one request per clock; each stage holds only while the stage after it is
// full and stalled, so empty stages keep filling while a result waits at the output.
// Reset: rst_n low clears every stage valid bit; payload registers are not reset.
// Depends on hsv2rgb_pkg, hsv2rgb_sector and hsv2rgb_scale.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_convert #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // hue[14:0], saturation[27:15], brightness[40:28], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // red[12:0], green[25:13], blue[38:26], zero pad
  output logic [0:0]  out_tuser   // chromatic[0]
);

  localparam int unsigned CHAN_W = hsv2rgb_pkg::CHAN_W;
  localparam int unsigned ONE    = 1 << FRAC_BITS;

  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic en1, en5;
  hsv2rgb_pkg::stage_en_t en;

  hsv2rgb_pkg::sector_t               s1_sector;
  logic [hsv2rgb_pkg::FRAC_W-1:0]     s1_frac;
  logic [hsv2rgb_pkg::FRAC_W-1:0]     s1_frac_c;
  logic [CHAN_W-1:0]                  s1_sat;
  logic [CHAN_W-1:0]                  s1_bright;
  hsv2rgb_pkg::side_t                 s1_side;
  hsv2rgb_pkg::side_t                 s2_side_r, s3_side_r, s4_side_r;

  logic [CHAN_W-1:0] p_lvl, q_lvl, t_lvl;
  logic [CHAN_W-1:0] red, green, blue;
  logic [39:0]       out_tdata_r;
  logic [0:0]        out_tuser_r;

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en5   = !out_valid_r || out_tready;
    en.s4 = !s4_valid_r || en5;
    en.s3 = !s3_valid_r || en.s4;
    en.s2 = !s2_valid_r || en.s3;
    en1   = !s1_valid_r || en.s2;
  end

  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_r <= in_tvalid;
      end
      if (en.s2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en.s3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (en.s4) begin
        s4_valid_r <= s3_valid_r;
      end
      if (en5) begin
        out_valid_r <= s4_valid_r;
      end
    end
  end

  hsv2rgb_sector u_sector (
    .clk        (clk),
    .en         (en1),
    .hue        (in_tdata[14:0]),
    .saturation (in_tdata[27:15]),
    .brightness (in_tdata[40:28]),
    .sector     (s1_sector),
    .frac       (s1_frac),
    .frac_c     (s1_frac_c),
    .sat        (s1_sat),
    .bright     (s1_bright)
  );

  hsv2rgb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_p (
    .clk    (clk),
    .en     (en),
    .sat    (s1_sat),
    .bright (s1_bright),
    .span   (hsv2rgb_pkg::FRAC_W'(hsv2rgb_pkg::HUE_SECTOR)),
    .level  (p_lvl)
  );

  hsv2rgb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_q (
    .clk    (clk),
    .en     (en),
    .sat    (s1_sat),
    .bright (s1_bright),
    .span   (s1_frac),
    .level  (q_lvl)
  );

  hsv2rgb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_t (
    .clk    (clk),
    .en     (en),
    .sat    (s1_sat),
    .bright (s1_bright),
    .span   (s1_frac_c),
    .level  (t_lvl)
  );

  always_comb begin
    s1_side.sector = s1_sector;
    s1_side.grey   = (s1_sat == '0);
    s1_side.vc     = (32'(s1_bright) > ONE) ? CHAN_W'(ONE) : s1_bright;
  end

  // carry sector, grey flag and clamped value alongside the term pipelines
  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_side_r <= s1_side;
    end
    if (en.s3) begin
      s3_side_r <= s2_side_r;
    end
    if (en.s4) begin
      s4_side_r <= s3_side_r;
    end
  end

  always_comb begin
    case (s4_side_r.sector)
      hsv2rgb_pkg::SECT_0: begin
        red = s4_side_r.vc; green = t_lvl;        blue = p_lvl;
      end
      hsv2rgb_pkg::SECT_1: begin
        red = q_lvl;        green = s4_side_r.vc; blue = p_lvl;
      end
      hsv2rgb_pkg::SECT_2: begin
        red = p_lvl;        green = s4_side_r.vc; blue = t_lvl;
      end
      hsv2rgb_pkg::SECT_3: begin
        red = p_lvl;        green = q_lvl;        blue = s4_side_r.vc;
      end
      hsv2rgb_pkg::SECT_4: begin
        red = t_lvl;        green = p_lvl;        blue = s4_side_r.vc;
      end
      default: begin
        red = s4_side_r.vc; green = p_lvl;        blue = q_lvl;
      end
    endcase
    if (s4_side_r.grey) begin
      red   = s4_side_r.vc;
      green = s4_side_r.vc;
      blue  = s4_side_r.vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_tdata_r <= {1'b0, blue, green, red};
      out_tuser_r <= !s4_side_r.grey;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

[rtl/core/hsv2rgb_checker.sv]
// Port-level checks of the HSV to RGB converter, bound to the top level.
// Depends on hsv_to_rgb_convert_macros.svh and hsv_to_rgb_convert.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_convert_macros.svh"

module hsv2rgb_checker #(
  parameter int unsigned FRAC_BITS = 12
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [0:0]  out_tuser
);

  localparam int unsigned ONE = 1 << FRAC_BITS;

  logic        stalled;
  logic [12:0] red;
  logic [12:0] green;
  logic [12:0] blue;

  assign stalled = out_tvalid && !out_tready;
  assign red     = out_tdata[12:0];
  assign green   = out_tdata[25:13];
  assign blue    = out_tdata[38:26];

  `HSV2RGB_ASSERT_RST(a_reset_empties, !rst_n |=> !out_tvalid, "output valid after reset")
  `HSV2RGB_ASSERT(a_stall_holds, stalled |=> out_tvalid && $stable({out_tuser, out_tdata}), "stalled result changed")
  `HSV2RGB_ASSERT(a_grey_equal, out_tvalid && !out_tuser[0] |-> red == green && green == blue, "grey result with unequal channels")
  `HSV2RGB_ASSERT(a_clamped, out_tvalid |-> 32'(red) <= ONE && 32'(green) <= ONE && 32'(blue) <= ONE, "channel above full scale")

endmodule

bind hsv_to_rgb_convert hsv2rgb_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[verif/hsv_to_rgb_convert_tb.sv]
// Self-checking testbench for hsv_to_rgb_convert: streams HSV requests, predicts each RGB
// result and compares in order while both sides idle and stall at random.
// Depends on hsv2rgb_pkg and the hsv_to_rgb_convert RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned HUE_W  = hsv2rgb_pkg::HUE_W;
  localparam int unsigned CHAN_W = hsv2rgb_pkg::CHAN_W;
  localparam int  FRAC_BITS   = 12;
  localparam int  STALL_LIMIT = 2000;
  localparam int  HOLD_CYCLES = 60;
  localparam int  DRAIN_TAIL  = 10;
  localparam int  PHASE_REQS  = 150;
  localparam int  UNIT        = 1 << FRAC_BITS;
  localparam int  SPAN        = 3840;
  localparam int  FULL_HUE    = 23040;
  localparam longint DEN      = longint'(UNIT) * SPAN;

  typedef struct {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bri;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              chromatic;
  } rgb_req_t;

  class rgb_scoreboard;
    rgb_req_t pending_rgb[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // v * num / DEN, truncated; negative terms give zero; clamp to 1.0
    static function longint scale_term(longint v, longint num);
      longint r;
      if (num <= 0) return 0;
      r = (v * num) / DEN;
      return (r > UNIT) ? longint'(UNIT) : r;
    endfunction

    static function rgb_req_t convert_hsv(logic [HUE_W-1:0] hue_in,
                                          logic [CHAN_W-1:0] sat_in,
                                          logic [CHAN_W-1:0] bri_in);
      rgb_req_t             res;
      longint               h, s, v, vc, f, p, q, t;
      hsv2rgb_pkg::sector_t sect;
      res.hue = hue_in;
      res.sat = sat_in;
      res.bri = bri_in;
      h = longint'(hue_in);
      s = longint'(sat_in);
      v = longint'(bri_in);
      vc = (v > UNIT) ? longint'(UNIT) : v;
      if (s == 0) begin
        res.red = CHAN_W'(vc);
        res.green = CHAN_W'(vc);
        res.blue = CHAN_W'(vc);
        res.chromatic = 1'b0;
        return res;
      end
      // hue of a full turn or more wraps to zero
      if (h >= FULL_HUE) h = 0;
      sect = hsv2rgb_pkg::sector_t'(h / SPAN);
      f = h % SPAN;
      p = scale_term(v, DEN - s * SPAN);
      q = scale_term(v, DEN - s * f);
      t = scale_term(v, DEN - s * (SPAN - f));
      case (sect)
        hsv2rgb_pkg::SECT_0: begin
          res.red = CHAN_W'(vc); res.green = CHAN_W'(t);  res.blue = CHAN_W'(p);
        end
        hsv2rgb_pkg::SECT_1: begin
          res.red = CHAN_W'(q);  res.green = CHAN_W'(vc); res.blue = CHAN_W'(p);
        end
        hsv2rgb_pkg::SECT_2: begin
          res.red = CHAN_W'(p);  res.green = CHAN_W'(vc); res.blue = CHAN_W'(t);
        end
        hsv2rgb_pkg::SECT_3: begin
          res.red = CHAN_W'(p);  res.green = CHAN_W'(q);  res.blue = CHAN_W'(vc);
        end
        hsv2rgb_pkg::SECT_4: begin
          res.red = CHAN_W'(t);  res.green = CHAN_W'(p);  res.blue = CHAN_W'(vc);
        end
        default: begin
          res.red = CHAN_W'(vc); res.green = CHAN_W'(p);  res.blue = CHAN_W'(q);
        end
      endcase
      res.chromatic = 1'b1;
      return res;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function int outstanding();
      return pending_rgb.size();
    endfunction

    function void note_request(logic [47:0] data);
      pending_rgb.push_back(convert_hsv(data[14:0], data[27:15], data[40:28]));
    endfunction

    task check_result(logic [39:0] data, logic [0:0] flags);
      rgb_req_t exp;
      string    ctx;
      if (pending_rgb.size() == 0) begin
        report($sformatf("result %h/%b with no request waiting", data, flags));
        return;
      end
      exp = pending_rgb.pop_front();
      ctx = $sformatf("h=%0d s=%0d v=%0d", exp.hue, exp.sat, exp.bri);
      if (data[12:0] !== exp.red)
        report($sformatf("%s red exp %0d got %0d", ctx, exp.red, data[12:0]));
      if (data[25:13] !== exp.green)
        report($sformatf("%s green exp %0d got %0d", ctx, exp.green, data[25:13]));
      if (data[38:26] !== exp.blue)
        report($sformatf("%s blue exp %0d got %0d", ctx, exp.blue, data[38:26]));
      if (flags[0] !== exp.chromatic)
        report($sformatf("%s chromatic exp %0b got %0b", ctx, exp.chromatic, flags[0]));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // hue[14:0], saturation[27:15], brightness[40:28], zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // red[12:0], green[25:13], blue[38:26], zero pad
  logic [0:0]  out_tuser;  // chromatic[0]

  rgb_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  bit hold_req;
  bit hold_done;
  int quiet_cycles;

  hsv_to_rgb_convert #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Note every request and result on the edge that moves it
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("hsv_to_rgb_convert regression: fail");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when asked for
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_request(input longint hue, input longint sat, input longint bri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, CHAN_W'(bri), CHAN_W'(sat), HUE_W'(hue)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic random_request();
    longint hue;
    longint sat;
    longint bri;
    int     kind;
    kind = $urandom_range(99);
    hue = longint'($urandom_range(FULL_HUE - 1));
    sat = longint'($urandom_range(UNIT));
    bri = longint'($urandom_range(UNIT));
    if (kind >= 70 && kind < 78) begin
      sat = 0;
      hue = longint'($urandom);
    end else if (kind >= 78 && kind < 86) begin
      // straddle a sector boundary at or just below full saturation
      hue = longint'(SPAN * $urandom_range(1, 6)) - longint'($urandom_range(1));
      sat = longint'(UNIT) - longint'($urandom_range(1));
      bri = UNIT;
    end else if (kind >= 86) begin
      hue = longint'($urandom);
      sat = longint'($urandom);
      bri = longint'($urandom);
    end
    send_request(hue, sat, bri);
  endtask

  // Hold the input low until every outstanding request has produced its result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: sector starts, wrap, grey, over-range inputs, all-ones fields
    for (int k = 0; k < 6; k++) send_request(SPAN * k, UNIT, UNIT);
    send_request(SPAN * 5 + 1920, UNIT, UNIT);
    send_request(1920, 1, UNIT);
    send_request(FULL_HUE - 1, UNIT, UNIT);
    send_request(FULL_HUE, UNIT, UNIT);
    send_request(32767, 2048, 3000);
    send_request(7000, 0, 0);
    send_request(7000, 0, UNIT);
    send_request(7000, 0, 8191);
    send_request(9000, 8191, UNIT);
    send_request(13000, 5000, 2500);
    send_request(3000, 2048, 8191);
    send_request(17000, UNIT, 0);
    send_request(SPAN - 1, UNIT, UNIT);
    send_request(SPAN * 2 + 100, 4095, 4095);
    send_request(32767, 8191, 8191);
    send_request(0, 0, 0);
    drain();

    // back-pressure: keep offering while the result side holds off
    hold_req = 1'b1;
    repeat (30) random_request();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      repeat (PHASE_REQS) random_request();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("hsv_to_rgb_convert regression: pass");
    end else begin
      $display("hsv_to_rgb_convert regression: fail");
    end
    $finish;
  end

endmodule

[hsv_to_rgb_convert.f]
+incdir+rtl/core
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_sector.sv
rtl/core/hsv2rgb_scale.sv
rtl/core/hsv_to_rgb_convert.sv
rtl/core/hsv2rgb_checker.sv
verif/hsv_to_rgb_convert_tb.sv
